// ===== rtl/kdc_pkg.sv =====
// kdc_pkg: shared types and constants of the keypad decimal calculator
// item structs, command and state encodings, key and display codes
// no dependencies
package kdc_pkg;

   // magnitude of the first operand, saturated at eight decimal digits
   localparam int unsigned MagW = 27;
   localparam logic [MagW-1:0] MagLimit = 27'd99999999;
   localparam int unsigned FirstDepth = 8;
   localparam int unsigned FIdxW = 3;
   localparam int unsigned FCntW = 4;
   localparam int unsigned BcdW = 32;
   localparam int unsigned IterW = 5;
   localparam logic [3:0] DigitMax = 4'd9;

   localparam logic [1:0] REQ_DIGIT  = 2'd0;
   localparam logic [1:0] REQ_OP     = 2'd1;
   localparam logic [1:0] REQ_CANCEL = 2'd2;
   localparam logic [1:0] REQ_RESET  = 2'd3;

   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_SUB   = 3'd1;
   localparam logic [2:0] OP_DIV   = 3'd2;
   localparam logic [2:0] OP_MUL   = 3'd3;
   localparam logic [2:0] OP_EQUAL = 3'd4;
   localparam logic [2:0] OP_NONE  = 3'd7;

   localparam logic [1:0] DISP_CLEAR  = 2'd0;
   localparam logic [1:0] DISP_APPEND = 2'd1;
   localparam logic [1:0] DISP_SIGN   = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic [3:0] key_digit;
      logic [2:0] op_code;
   } kdc_req_item_type;

   typedef struct packed {
      logic [1:0] disp_cmd;
      logic [3:0] disp_digit;
      logic       disp_negative;
      logic       div_error;
      logic       last;
   } kdc_rsp_item_type;

   typedef enum logic [2:0] {
      CMD_DIGIT,
      CMD_LATCH,
      CMD_CLEAR,
      CMD_EQUAL,
      CMD_CANCEL,
      CMD_RESET
   } kdc_cmd_kind_type;

   typedef struct packed {
      kdc_cmd_kind_type kind;
      logic [3:0]       digit;
      logic [2:0]       op;
   } kdc_cmd_type;

   typedef struct packed {
      logic        valid;
      kdc_cmd_type cmd;
   } kdc_queue_out_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD_A,
      ST_LOAD_B,
      ST_EXEC,
      ST_MUL,
      ST_DIV,
      ST_CLAMP,
      ST_BCD,
      ST_STORE,
      ST_SHOW_CLR,
      ST_SHOW_SIGN,
      ST_SHOW_DIG
   } kdc_state_type;

endpackage

// ===== rtl/keypad_decimal_calculator.sv =====
// keypad_decimal_calculator: top level of the four-function keypad calculator
// depends on kdc_pkg, kdc_front, kdc_queue, kdc_back
//
// req channel: one keypad item (digit, operation, cancel, reset) per handshake,
// accepted when req_valid is high and req_stall low. rsp channel: display items
// (clear, append digit, set sign) with last on the final item of each key.
// Keys pass a decoder into a two-entry queue, so up to two keys are taken
// while the back end works or the display stalls.
// A digit key with room left, an operation or a cancel key gives its one item,
// registered when the back end takes it from the queue. Equal converts the
// first and then the second operand digit by digit, takes a setup step, then
// runs a shift-add multiply over the bits of the second operand (14 for four
// digits) or a restoring divide over the 27 bits of the first, a clamp step,
// a binary to decimal conversion and a store of the result digits, then gives
// one display item per cycle while the output register is free or rsp_stall is low.
// rsp_stall holds the output register; the back end waits and the queue fills,
// then req_stall rises. Reset clears counts, sign and pending operation; no
// clearing pass is needed. A reset key does the same and sends nothing.
module keypad_decimal_calculator #(
   parameter int unsigned MAX_DIGITS = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  kdc_pkg::kdc_req_item_type req_item,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output kdc_pkg::kdc_rsp_item_type rsp_item
);

   logic                       q_full, q_push, q_pop;
   kdc_pkg::kdc_cmd_type       q_cmd;
   kdc_pkg::kdc_queue_out_type q_out;

   kdc_front u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   kdc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .cmd   (q_cmd),
      .full  (q_full),
      .pop   (q_pop),
      .q_out (q_out)
   );

   kdc_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_in      (q_out),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== rtl/kdc_front.sv =====
// kdc_front: accepts keypad items and classifies them into commands
// depends on kdc_pkg; feeds kdc_queue
module kdc_front (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  kdc_pkg::kdc_req_item_type req_item,
   input  logic                      q_full,
   output logic                      q_push,
   output kdc_pkg::kdc_cmd_type      q_cmd
);

   logic keep;

   always_comb begin
      q_cmd.digit = req_item.key_digit;
      q_cmd.op    = req_item.op_code;
      q_cmd.kind  = kdc_pkg::CMD_CLEAR;
      keep        = 1'b1;
      unique case (req_item.req_type)
         kdc_pkg::REQ_DIGIT: begin
            q_cmd.kind = kdc_pkg::CMD_DIGIT;
            // digits above nine vanish here
            keep = (req_item.key_digit <= kdc_pkg::DigitMax);
         end
         kdc_pkg::REQ_OP: begin
            if (req_item.op_code == kdc_pkg::OP_EQUAL) begin
               q_cmd.kind = kdc_pkg::CMD_EQUAL;
            end else if (req_item.op_code < kdc_pkg::OP_EQUAL) begin
               q_cmd.kind = kdc_pkg::CMD_LATCH;
            end else begin
               q_cmd.kind = kdc_pkg::CMD_CLEAR;
            end
         end
         kdc_pkg::REQ_CANCEL: q_cmd.kind = kdc_pkg::CMD_CANCEL;
         kdc_pkg::REQ_RESET:  q_cmd.kind = kdc_pkg::CMD_RESET;
         default:             q_cmd.kind = kdc_pkg::CMD_CLEAR;
      endcase
   end

   assign req_stall = q_full;
   assign q_push    = req_valid & ~q_full & keep;

endmodule

// ===== rtl/kdc_queue.sv =====
// kdc_queue: two-entry command queue between front and back
// depends on kdc_pkg
module kdc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  kdc_pkg::kdc_cmd_type       cmd,
   output logic                       full,
   input  logic                       pop,
   output kdc_pkg::kdc_queue_out_type q_out
);

   kdc_pkg::kdc_cmd_type mem_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wr_ff, rd_ff;

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= cmd;
   end

   assign full        = (cnt_ff == 2'd2);
   assign q_out.valid = (cnt_ff != 2'd0);
   assign q_out.cmd   = mem_ff[rd_ff];

endmodule

// ===== rtl/kdc_back.sv =====
// kdc_back: operand stores, sequencer, iterative arithmetic and display output
// depends on kdc_pkg; takes commands from kdc_queue
module kdc_back #(
   parameter int unsigned MAX_DIGITS = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  kdc_pkg::kdc_queue_out_type q_in,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output kdc_pkg::kdc_rsp_item_type  rsp_item
);

   localparam int unsigned SecTop = 10 ** MAX_DIGITS;
   localparam int unsigned BW     = $clog2(SecTop);
   localparam int unsigned RW     = kdc_pkg::MagW + BW;
   localparam int unsigned SCntW  = $clog2(MAX_DIGITS + 1);
   localparam int unsigned SIdxW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int unsigned MW     = kdc_pkg::MagW;

   kdc_pkg::kdc_state_type state_ff, state_in;

   logic [3:0] fd_ff [kdc_pkg::FirstDepth];
   logic [3:0] sd_ff [MAX_DIGITS];
   logic [kdc_pkg::FCntW-1:0] fcnt_ff, fcnt_in;
   logic [SCntW-1:0]          scnt_ff, scnt_in;
   logic [2:0]                pend_ff, pend_in;
   logic                      neg_ff, neg_in;

   logic [MW-1:0]             a_ff, a_in;
   logic [BW-1:0]             b_ff, b_in;
   logic [RW-1:0]             acc_ff, acc_in;
   logic [BW-1:0]             rem_ff, rem_in;
   logic [kdc_pkg::IterW-1:0] iter_ff, iter_in;
   logic [kdc_pkg::BcdW-1:0]  bcd_ff, bcd_in;
   logic [3:0]                idx_ff, idx_in;
   logic                      sign_ff, sign_in;
   logic                      err_ff, err_in;

   logic                      rsp_valid_ff;
   kdc_pkg::kdc_rsp_item_type rsp_ff;

   logic                      fd_we, sd_we;
   logic [kdc_pkg::FIdxW-1:0] fd_wa;
   logic [SIdxW-1:0]          sd_wa;
   logic [3:0]                fd_wd, sd_wd;

   logic                      emit;
   kdc_pkg::kdc_rsp_item_type emit_item;

   logic                      out_can, take, dig_ok;
   kdc_pkg::kdc_cmd_type      cmd;
   logic [3:0]                fd_rd, sd_rd;
   logic [MW+3:0]             a_ext, a_x10;
   logic [BW+3:0]             b_ext, b_x10;
   logic [RW-1:0]             a_big, b_big, sum_ab, diff_ab, diff_ba;
   logic                      a_ge_b, b_ge_a;
   logic [BW:0]               trial;
   logic                      q_bit;
   logic [kdc_pkg::BcdW-1:0]  bcd_adj;
   logic [3:0]                nsig, sel;
   logic [3:0]                nib;

   assign out_can = ~rsp_valid_ff | ~rsp_stall;
   assign take    = (state_ff == kdc_pkg::ST_IDLE) & q_in.valid & out_can;
   assign q_pop   = take;
   assign cmd     = q_in.cmd;
   assign dig_ok  = (fcnt_ff < kdc_pkg::FCntW'(MAX_DIGITS)) &
                    (scnt_ff < SCntW'(MAX_DIGITS));

   assign fd_rd = fd_ff[idx_ff[kdc_pkg::FIdxW-1:0]];
   assign sd_rd = sd_ff[idx_ff[SIdxW-1:0]];

   // decimal to binary, one digit a cycle
   assign a_ext = {4'd0, a_ff};
   assign a_x10 = (a_ext << 3) + (a_ext << 1) + {{MW{1'b0}}, fd_rd};
   assign b_ext = {4'd0, b_ff};
   assign b_x10 = (b_ext << 3) + (b_ext << 1) + {{BW{1'b0}}, sd_rd};

   assign a_big   = RW'(a_ff);
   assign b_big   = RW'(b_ff);
   assign sum_ab  = a_big + b_big;
   assign diff_ab = a_big - b_big;
   assign diff_ba = b_big - a_big;
   assign a_ge_b  = (a_big >= b_big);
   assign b_ge_a  = (b_big >= a_big);

   // restoring divide step
   assign trial = {rem_ff, a_ff[MW-1]};
   assign q_bit = (trial >= {1'b0, b_ff});

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         bcd_adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                       : bcd_ff[i*4 +: 4];
      end
   end

   // count of significant result digits
   always_comb begin
      nsig = 4'd0;
      for (int i = 0; i < 8; i++) begin
         if (bcd_ff[i*4 +: 4] != 4'd0) nsig = 4'(i + 1);
      end
   end

   assign sel = nsig - 4'd1 - idx_ff;
   assign nib = bcd_ff[{sel[2:0], 2'b00} +: 4];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kdc_pkg::ST_IDLE: begin
            if (take && cmd.kind == kdc_pkg::CMD_EQUAL) state_in = kdc_pkg::ST_LOAD_A;
         end
         kdc_pkg::ST_LOAD_A: begin
            if (idx_ff == fcnt_ff) state_in = kdc_pkg::ST_LOAD_B;
         end
         kdc_pkg::ST_LOAD_B: begin
            if (idx_ff == 4'(scnt_ff)) state_in = kdc_pkg::ST_EXEC;
         end
         kdc_pkg::ST_EXEC: begin
            unique case (pend_ff)
               kdc_pkg::OP_ADD, kdc_pkg::OP_SUB: state_in = kdc_pkg::ST_CLAMP;
               kdc_pkg::OP_MUL: state_in = kdc_pkg::ST_MUL;
               kdc_pkg::OP_DIV: begin
                  state_in = (b_ff == '0) ? kdc_pkg::ST_SHOW_CLR : kdc_pkg::ST_DIV;
               end
               default: state_in = kdc_pkg::ST_SHOW_CLR;
            endcase
         end
         kdc_pkg::ST_MUL: begin
            if (iter_ff == kdc_pkg::IterW'(BW - 1)) state_in = kdc_pkg::ST_CLAMP;
         end
         kdc_pkg::ST_DIV: begin
            if (iter_ff == kdc_pkg::IterW'(MW - 1)) state_in = kdc_pkg::ST_CLAMP;
         end
         kdc_pkg::ST_CLAMP: state_in = kdc_pkg::ST_BCD;
         kdc_pkg::ST_BCD: begin
            if (iter_ff == kdc_pkg::IterW'(MW - 1)) state_in = kdc_pkg::ST_STORE;
         end
         kdc_pkg::ST_STORE: begin
            if (idx_ff == nsig) state_in = kdc_pkg::ST_SHOW_CLR;
         end
         kdc_pkg::ST_SHOW_CLR: begin
            if (out_can) state_in = kdc_pkg::ST_SHOW_SIGN;
         end
         kdc_pkg::ST_SHOW_SIGN: begin
            if (out_can) begin
               state_in = (fcnt_ff == '0) ? kdc_pkg::ST_IDLE : kdc_pkg::ST_SHOW_DIG;
            end
         end
         kdc_pkg::ST_SHOW_DIG: begin
            if (out_can && (idx_ff + 4'd1 == fcnt_ff)) state_in = kdc_pkg::ST_IDLE;
         end
         default: state_in = kdc_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      fcnt_in = fcnt_ff;
      scnt_in = scnt_ff;
      pend_in = pend_ff;
      neg_in  = neg_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      iter_in = iter_ff;
      bcd_in  = bcd_ff;
      idx_in  = idx_ff;
      sign_in = sign_ff;
      err_in  = err_ff;
      fd_we   = 1'b0;
      fd_wa   = fcnt_ff[kdc_pkg::FIdxW-1:0];
      fd_wd   = cmd.digit;
      sd_we   = 1'b0;
      sd_wa   = scnt_ff[SIdxW-1:0];
      sd_wd   = cmd.digit;
      emit    = 1'b0;
      emit_item = '{disp_cmd: kdc_pkg::DISP_CLEAR, disp_digit: 4'd0,
                    disp_negative: 1'b0, div_error: err_ff, last: 1'b0};
      unique case (state_ff)
         kdc_pkg::ST_IDLE: begin
            if (take) begin
               emit_item.div_error = 1'b0;
               emit_item.last      = 1'b1;
               unique case (cmd.kind)
                  kdc_pkg::CMD_DIGIT: begin
                     if (dig_ok) begin
                        emit = 1'b1;
                        emit_item.disp_cmd   = kdc_pkg::DISP_APPEND;
                        emit_item.disp_digit = cmd.digit;
                        if (pend_ff == kdc_pkg::OP_NONE) begin
                           fd_we   = 1'b1;
                           fcnt_in = fcnt_ff + 4'd1;
                        end else begin
                           sd_we   = 1'b1;
                           scnt_in = scnt_ff + SCntW'(1);
                        end
                     end
                  end
                  kdc_pkg::CMD_LATCH: begin
                     emit    = 1'b1;
                     pend_in = cmd.op;
                  end
                  kdc_pkg::CMD_CLEAR: emit = 1'b1;
                  kdc_pkg::CMD_CANCEL: begin
                     emit = 1'b1;
                     if (pend_ff == kdc_pkg::OP_NONE) begin
                        fcnt_in = '0;
                        neg_in  = 1'b0;
                     end else begin
                        scnt_in = '0;
                     end
                  end
                  kdc_pkg::CMD_RESET: begin
                     fcnt_in = '0;
                     scnt_in = '0;
                     pend_in = kdc_pkg::OP_NONE;
                     neg_in  = 1'b0;
                  end
                  kdc_pkg::CMD_EQUAL: begin
                     a_in   = '0;
                     b_in   = '0;
                     idx_in = 4'd0;
                     err_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         kdc_pkg::ST_LOAD_A: begin
            if (idx_ff == fcnt_ff) begin
               idx_in = 4'd0;
            end else begin
               a_in   = a_x10[MW-1:0];
               idx_in = idx_ff + 4'd1;
            end
         end
         kdc_pkg::ST_LOAD_B: begin
            if (idx_ff == 4'(scnt_ff)) begin
               scnt_in = '0;
            end else begin
               b_in   = b_x10[BW-1:0];
               idx_in = idx_ff + 4'd1;
            end
         end
         kdc_pkg::ST_EXEC: begin
            iter_in = '0;
            rem_in  = '0;
            sign_in = neg_ff;
            unique case (pend_ff)
               kdc_pkg::OP_ADD: begin
                  if (!neg_ff) begin
                     acc_in  = sum_ab;
                     sign_in = 1'b0;
                  end else if (b_ge_a) begin
                     acc_in  = diff_ba;
                     sign_in = 1'b0;
                  end else begin
                     acc_in  = diff_ab;
                     sign_in = 1'b1;
                  end
               end
               kdc_pkg::OP_SUB: begin
                  if (neg_ff) begin
                     acc_in  = sum_ab;
                     sign_in = 1'b1;
                  end else if (a_ge_b) begin
                     acc_in  = diff_ab;
                     sign_in = 1'b0;
                  end else begin
                     acc_in  = diff_ba;
                     sign_in = 1'b1;
                  end
               end
               kdc_pkg::OP_MUL: acc_in = '0;
               kdc_pkg::OP_DIV: begin
                  acc_in = '0;
                  if (b_ff == '0) err_in = 1'b1;
               end
               default: ;
            endcase
         end
         kdc_pkg::ST_MUL: begin
            // msb-first shift and add
            acc_in  = {acc_ff[RW-2:0], 1'b0} + (b_ff[BW-1] ? a_big : '0);
            b_in    = {b_ff[BW-2:0], 1'b0};
            iter_in = iter_ff + kdc_pkg::IterW'(1);
         end
         kdc_pkg::ST_DIV: begin
            rem_in  = q_bit ? BW'(trial - {1'b0, b_ff}) : trial[BW-1:0];
            a_in    = {a_ff[MW-2:0], 1'b0};
            acc_in  = {acc_ff[RW-2:0], q_bit};
            iter_in = iter_ff + kdc_pkg::IterW'(1);
         end
         kdc_pkg::ST_CLAMP: begin
            a_in    = (acc_ff > RW'(kdc_pkg::MagLimit)) ? kdc_pkg::MagLimit : acc_ff[MW-1:0];
            sign_in = sign_ff & (acc_ff != '0);
            bcd_in  = '0;
            iter_in = '0;
         end
         kdc_pkg::ST_BCD: begin
            // double dabble, one bit a cycle
            bcd_in  = {bcd_adj[kdc_pkg::BcdW-2:0], a_ff[MW-1]};
            a_in    = {a_ff[MW-2:0], 1'b0};
            iter_in = iter_ff + kdc_pkg::IterW'(1);
            idx_in  = 4'd0;
         end
         kdc_pkg::ST_STORE: begin
            if (idx_ff == nsig) begin
               fcnt_in = nsig;
               neg_in  = sign_ff;
            end else begin
               fd_we  = 1'b1;
               fd_wa  = idx_ff[kdc_pkg::FIdxW-1:0];
               fd_wd  = nib;
               idx_in = idx_ff + 4'd1;
            end
         end
         kdc_pkg::ST_SHOW_CLR: begin
            emit = out_can;
         end
         kdc_pkg::ST_SHOW_SIGN: begin
            emit = out_can;
            emit_item.disp_cmd      = kdc_pkg::DISP_SIGN;
            emit_item.disp_negative = neg_ff;
            emit_item.last          = (fcnt_ff == '0);
            idx_in = 4'd0;
         end
         kdc_pkg::ST_SHOW_DIG: begin
            emit = out_can;
            emit_item.disp_cmd   = kdc_pkg::DISP_APPEND;
            emit_item.disp_digit = fd_rd;
            emit_item.last       = (idx_ff + 4'd1 == fcnt_ff);
            if (out_can) idx_in = idx_ff + 4'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kdc_pkg::ST_IDLE;
         fcnt_ff      <= '0;
         scnt_ff      <= '0;
         pend_ff      <= kdc_pkg::OP_NONE;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fcnt_ff  <= fcnt_in;
         scnt_ff  <= scnt_in;
         pend_ff  <= pend_in;
         neg_ff   <= neg_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      iter_ff <= iter_in;
      bcd_ff  <= bcd_in;
      idx_ff  <= idx_in;
      sign_ff <= sign_in;
      err_ff  <= err_in;
      if (emit) rsp_ff <= emit_item;
      if (fd_we) fd_ff[fd_wa] <= fd_wd;
      if (sd_we) sd_ff[sd_wa] <= sd_wd;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
